// ----- design/sawarq_pkg.sv -----
// Shared types and constants for the stop-and-wait ARQ sender.
// Used by every module of the block; no dependencies.
package sawarq_pkg;

  localparam int unsigned MaxPayloadDef = 32;
  localparam logic [15:0] RetransmitReset = 16'd100;
  localparam logic [63:0] TokenReset = 64'd0;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgRetransmit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgToken = 1'b1;

  // input item modes
  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModePayload = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;
  localparam logic [1:0] ModeAck = 2'd3;

  // result types
  localparam logic [1:0] ResStatus = 2'd0;
  localparam logic [1:0] ResHeader = 2'd1;
  localparam logic [1:0] ResByte = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  msg_kind;
    logic [7:0]  msg_length;
    logic [7:0]  data_byte;
    logic [31:0] ack_seq;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_type;
    logic        accepted;
    logic [31:0] out_seq;
    logic [7:0]  out_kind;
    logic [5:0]  out_length;
    logic [63:0] out_token;
    logic [7:0]  out_byte;
    logic        last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic emit_byte;  // load next payload byte into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register empty or draining this cycle
    logic tx_due;     // current input is a tick that starts a transmission
    logic has_bytes;  // held message has a nonzero length
    logic byte_last;  // byte being emitted is the final one
  } status_t;

endpackage

// ----- design/sawarq_ctrl.sv -----
// Transmit sequencer for the stop-and-wait ARQ sender.
// Depends on sawarq_pkg for command and status types.
module sawarq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sawarq_pkg::status_t status_i,
  output sawarq_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;  // store read in flight
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = status_i.slot_free;
        if (in_valid_i && status_i.slot_free) begin
          cmd_o.take = 1'b1;
          if (status_i.tx_due && status_i.has_bytes) begin
            state_d = StFetch;
          end
        end
      end
      StFetch: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (status_i.slot_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d = status_i.byte_last ? StIdle : StFetch;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/sawarq_dp.sv -----
// Datapath for the stop-and-wait ARQ sender: message state, timer, payload
// store, config registers and output register. Depends on sawarq_pkg.
module sawarq_dp #(
  parameter int unsigned MAX_PAYLOAD = sawarq_pkg::MaxPayloadDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sawarq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sawarq_pkg::CfgDataW-1:0]   cfg_data_i,
  input  sawarq_pkg::in_t                   in_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output sawarq_pkg::out_t                  out_data_o,
  input  sawarq_pkg::cmd_t                  cmd_i,
  output sawarq_pkg::status_t               status_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [15:0] retx_q;
  logic [63:0] token_q;

  logic        pending_q, loading_q;
  logic [31:0] seq_q;
  logic [7:0]  kind_q;
  logic [5:0]  len_q;
  logic [5:0]  load_cnt_q;
  logic [15:0] ticks_q;
  logic [5:0]  byte_idx_q;

  logic [7:0]  mem [MAX_PAYLOAD];
  logic [7:0]  rd_q;

  logic             out_valid_q;
  sawarq_pkg::out_t out_q, out_d;

  logic [15:0] ticks_dec;
  logic        is_start, is_payload, is_tick, is_ack;
  logic        start_ok, load_ok, load_done, ack_hit;
  logic [5:0]  load_cnt_inc;
  logic [5:0]  byte_idx_inc;

  always_comb begin
    is_start = in_data_i.mode == sawarq_pkg::ModeStart;
    is_payload = in_data_i.mode == sawarq_pkg::ModePayload;
    is_tick = in_data_i.mode == sawarq_pkg::ModeTick;
    is_ack = in_data_i.mode == sawarq_pkg::ModeAck;
    ticks_dec = (ticks_q != 16'd0) ? ticks_q - 16'd1 : ticks_q;
    start_ok = !pending_q && !loading_q && (in_data_i.msg_length <= MaxLen);
    load_ok = loading_q && (load_cnt_q < len_q);
    load_cnt_inc = load_cnt_q + 6'd1;
    load_done = load_cnt_inc >= len_q;
    ack_hit = pending_q && (in_data_i.ack_seq == seq_q);
    byte_idx_inc = byte_idx_q + 6'd1;

    status_o.slot_free = !out_valid_q || out_ready_i;
    status_o.tx_due = is_tick && pending_q && !loading_q && (ticks_dec == 16'd0);
    status_o.has_bytes = len_q != 6'd0;
    status_o.byte_last = byte_idx_inc == len_q;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retx_q <= sawarq_pkg::RetransmitReset;
      token_q <= sawarq_pkg::TokenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sawarq_pkg::CfgRetransmit: retx_q <= cfg_data_i[15:0];
        sawarq_pkg::CfgToken:      token_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // message state and timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      loading_q <= 1'b0;
      seq_q <= '0;
      kind_q <= '0;
      len_q <= '0;
      load_cnt_q <= '0;
      ticks_q <= '0;
      byte_idx_q <= '0;
    end else begin
      if (cmd_i.take) begin
        if (is_start && start_ok) begin
          kind_q <= in_data_i.msg_kind;
          len_q <= in_data_i.msg_length[5:0];
          load_cnt_q <= '0;
          if (in_data_i.msg_length == 8'd0) begin
            pending_q <= 1'b1;
            ticks_q <= '0;
          end else begin
            loading_q <= 1'b1;
          end
        end
        if (is_payload && load_ok) begin
          load_cnt_q <= load_cnt_inc;
          if (load_done) begin
            loading_q <= 1'b0;
            pending_q <= 1'b1;
            ticks_q <= '0;
          end
        end
        if (is_tick && pending_q && !loading_q) begin
          ticks_q <= status_o.tx_due ? retx_q : ticks_dec;
          byte_idx_q <= '0;
        end
        if (is_ack && ack_hit) begin
          pending_q <= 1'b0;
          seq_q <= seq_q + 32'd1;
        end
      end
      if (cmd_i.emit_byte) begin
        byte_idx_q <= byte_idx_inc;
      end
    end
  end

  // payload store; read address follows the transmit index
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_payload && load_ok) begin
      mem[load_cnt_q[AW-1:0]] <= in_data_i.data_byte;
    end
    rd_q <= mem[byte_idx_q[AW-1:0]];
  end

  // output register
  always_comb begin
    out_d = '0;
    if (cmd_i.emit_byte) begin
      out_d.result_type = sawarq_pkg::ResByte;
      out_d.out_byte = rd_q;
      out_d.last = status_o.byte_last;
    end else if (status_o.tx_due) begin
      out_d.result_type = sawarq_pkg::ResHeader;
      out_d.out_seq = seq_q;
      out_d.out_kind = kind_q;
      out_d.out_length = len_q;
      out_d.out_token = token_q;
      out_d.last = len_q == 6'd0;
    end else begin
      out_d.result_type = sawarq_pkg::ResStatus;
      out_d.accepted = start_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_byte || (cmd_i.take && (is_start || status_o.tx_due))) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_byte || (cmd_i.take && (is_start || status_o.tx_due))) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ----- design/stop_and_wait_arq_sender.sv -----
// Stop-and-wait ARQ sender. Start, payload, ack and non-due tick beats leave the
// sequencer idle; a start status or header shows in the output register in the cycle
// after its input beat. A due tick with payload blocks input until each payload byte
// has had a store read and then an output step; a stalled output holds the bytes back.
// Async active-low reset clears control and config; the payload store is not cleared.
module stop_and_wait_arq_sender #(
  parameter int unsigned MAX_PAYLOAD = sawarq_pkg::MaxPayloadDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sawarq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sawarq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sawarq_pkg::in_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sawarq_pkg::out_t                out_data_o
);

  sawarq_pkg::cmd_t    cmd;
  sawarq_pkg::status_t status;

  sawarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sawarq_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- design/sawarq_chk.sv -----
// Port-level checker for the stop-and-wait ARQ sender, bound to the top level.
// Depends on sawarq_pkg for payload types and codes.
module sawarq_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input sawarq_pkg::in_t  in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input sawarq_pkg::out_t out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // every accepted start beat answers with a status next cycle
  a_start_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.mode == sawarq_pkg::ModeStart
    |=> out_valid_o && out_data_o.result_type == sawarq_pkg::ResStatus)
    else $error("start beat without status");

  // header-only run must close itself
  a_empty_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_type == sawarq_pkg::ResHeader
    && out_data_o.out_length == 6'd0 |-> out_data_o.last)
    else $error("zero-length header without last");

  // status carries no last flag, token or byte content
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_type == sawarq_pkg::ResStatus
    |-> !out_data_o.last && out_data_o.out_token == 64'd0 && out_data_o.out_byte == 8'd0)
    else $error("status beat carries stray fields");

endmodule

bind stop_and_wait_arq_sender sawarq_chk u_chk (.*);
